>>> hw/rtl/pee_pkg.sv
// Shared constants and types for the postfix expression evaluator.
package pee_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int WORD_W = 32;

  localparam logic [7:0] SYM_ADD  = 8'h2B;
  localparam logic [7:0] SYM_SUB  = 8'h2D;
  localparam logic [7:0] SYM_MUL  = 8'h2A;
  localparam logic [7:0] SYM_DIV  = 8'h2F;
  localparam logic [7:0] SYM_ZERO = 8'h30;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SYM,
    S_RD_B,
    S_CALC,
    S_DIV,
    S_WB,
    S_FINISH,
    S_REPORT
  } state_t;

endpackage

>>> hw/rtl/pee_stack.sv
// Operand stack memory: one write port, one read port with registered data.
module pee_stack import pee_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int AW = $clog2(STACK_DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/pee_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module pee_div import pee_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(WORD_W);

  logic              running;
  logic              fix;
  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic [WORD_W-1:0] dvd;
  logic [WORD_W-1:0] dsr;
  logic [WORD_W-1:0] rem;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic              ge;

  assign shifted = {rem, dvd[WORD_W-1]};
  assign ge      = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fix     <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      fix  <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(WORD_W - 1)) begin
          running <= 1'b0;
          fix     <= 1'b1;
        end
      end
      if (fix) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      dvd <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
      dsr <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
      rem <= '0;
    end else if (running) begin
      rem <= ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
      dvd <= {dvd[WORD_W-2:0], ge};
    end
    if (fix) begin
      quotient <= neg ? (WORD_W'(0) - dvd) : dvd;
    end
  end

endmodule

>>> hw/rtl/postfix_expression_evaluator.sv
// Top level of the postfix expression evaluator: control sequencer and datapath.
//
// Usage:
//   Input: drive symbol and is_final and raise start; the beat is taken on a
//   rising edge with start high and busy low. busy stays high while the byte
//   is worked on. Operand bytes push (symbol - 48); + - * / pop a, then b, and
//   push b op a with 32-bit wrapping arithmetic, division truncating to zero.
//   Output: on the last byte of an expression (is_final high) one result beat
//   appears on value and status with result_valid high for exactly one cycle.
//   There is no stall on the result side; the beat is gone after that cycle.
//   Status: 0 ok, 1 underflow, 2 overflow, 3 divide by zero, 4 empty stack;
//   value is zero unless status is ok. After the report the stack is emptied.
//   Per byte: an operand push passes through S_SYM and S_FINISH; + - * also
//   read both operands (S_RD_B, S_CALC) and write back (S_WB); / waits in
//   S_DIV for the divider loop with its setup and fix-up, the longest path.
//   A final byte that reports a stack value adds the top-of-stack read in
//   S_REPORT; result_valid rises in the same cycle that busy falls. The stack
//   sits in a single-port-read memory; each operand read is registered. Reset
//   empties the stack and clears the error; stack contents need no clearing.
module postfix_expression_evaluator import pee_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [7:0]               symbol,
  input  logic                     is_final,
  output logic                     result_valid,
  output logic signed [WORD_W-1:0] value,
  output logic [2:0]               status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  status_t           err, err_next;
  logic [7:0]        sym;
  logic              fin;
  logic [WORD_W-1:0] opa, opa_next;
  logic [WORD_W-1:0] res, res_next;

  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;
  logic              is_op;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;

  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_q;

  logic              out_fire;
  logic [WORD_W-1:0] out_value;
  status_t           out_status;

  assign busy   = state != S_IDLE;
  assign cnt_m1 = count - CW'(1);
  assign cnt_m2 = count - CW'(2);
  assign is_op  = sym inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV};

  pee_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .AW         (AW)
  ) u_stack (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  pee_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(rd_data),
    .divisor (opa),
    .done    (div_done),
    .quotient(div_q)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    err_next   = err;
    opa_next   = opa;
    res_next   = res;
    wr_en      = 1'b0;
    wr_addr    = count[AW-1:0];
    wr_data    = {24'd0, sym} - {24'd0, SYM_ZERO};
    rd_en      = 1'b0;
    rd_addr    = cnt_m1[AW-1:0];
    div_start  = 1'b0;
    out_fire   = 1'b0;
    out_value  = '0;
    out_status = ST_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SYM;
        end
      end
      S_SYM: begin
        state_next = S_FINISH;
        if (err == ST_OK) begin
          if (is_op) begin
            if (count < CW'(2)) begin
              err_next = ST_UNDERFLOW;
            end else begin
              rd_en      = 1'b1;
              state_next = S_RD_B;
            end
          end else if (count >= CW'(STACK_DEPTH)) begin
            err_next = ST_OVERFLOW;
          end else begin
            wr_en      = 1'b1;
            count_next = count + CW'(1);
          end
        end
      end
      S_RD_B: begin
        opa_next   = rd_data;
        rd_en      = 1'b1;
        rd_addr    = cnt_m2[AW-1:0];
        state_next = S_CALC;
      end
      S_CALC: begin
        case (sym)
          SYM_ADD: begin
            res_next   = rd_data + opa;
            state_next = S_WB;
          end
          SYM_SUB: begin
            res_next   = rd_data - opa;
            state_next = S_WB;
          end
          SYM_MUL: begin
            res_next   = WORD_W'(rd_data * opa);
            state_next = S_WB;
          end
          default: begin
            if (opa == '0) begin
              err_next   = ST_DIVZERO;
              state_next = S_FINISH;
            end else begin
              div_start  = 1'b1;
              state_next = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          res_next   = div_q;
          state_next = S_WB;
        end
      end
      S_WB: begin
        wr_en      = 1'b1;
        wr_addr    = cnt_m2[AW-1:0];
        wr_data    = res;
        count_next = cnt_m1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        state_next = S_IDLE;
        if (fin) begin
          if (err != ST_OK) begin
            out_fire   = 1'b1;
            out_status = err;
            count_next = '0;
            err_next   = ST_OK;
          end else if (count == '0) begin
            out_fire   = 1'b1;
            out_status = ST_EMPTY;
          end else begin
            rd_en      = 1'b1;
            state_next = S_REPORT;
          end
        end
      end
      S_REPORT: begin
        out_fire   = 1'b1;
        out_value  = rd_data;
        count_next = '0;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      err          <= ST_OK;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      err          <= err_next;
      result_valid <= out_fire;
    end
  end

  always_ff @(posedge clk) begin
    opa <= opa_next;
    res <= res_next;
    if (start && !busy) begin
      sym <= symbol;
      fin <= is_final;
    end
    if (out_fire) begin
      value  <= out_value;
      status <= out_status;
    end
  end

`ifndef ASSERT_OFF
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result beat longer than one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_OK |-> value == '0)
    else $error("nonzero value with error status");

  a_cleared_after_report: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> count == '0 && err == ST_OK)
    else $error("stack not cleared after report");

  a_div_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its wait state");
`endif

endmodule

>>> tb/postfix_expression_evaluator_test.sv
// Self-checking testbench for the postfix expression evaluator: directed cases, then random RPN streams.
`timescale 1ns / 1ps

module postfix_expression_evaluator_test;
  import pee_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASE_BEATS = 425;
  localparam logic [7:0] OPERATORS [4] = '{SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV};

  typedef struct {
    logic signed [WORD_W-1:0] value;
    status_t                  status;
  } rpn_result_t;

  class rpn_result_board;
    logic [WORD_W-1:0] stack_mem [STACK_DEPTH_DEF];
    int                depth = 0;
    status_t           first_error = ST_OK;
    rpn_result_t       pending [$];
    int                failures = 0;
    int                results_seen = 0;
    int                status_seen [5] = '{default: 0};

    function void take_symbol(logic [7:0] sym, logic fin);
      logic [WORD_W-1:0] a, b, r, mag_a, mag_b, quo;
      bit                is_op;
      rpn_result_t       res;
      is_op = sym inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV};
      if (first_error == ST_OK) begin
        if (is_op) begin
          if (depth < 2) begin
            first_error = ST_UNDERFLOW;
          end else begin
            a = stack_mem[depth-1];
            b = stack_mem[depth-2];
            r = '0;
            case (sym)
              SYM_ADD: r = b + a;
              SYM_SUB: r = b - a;
              SYM_MUL: r = b * a;
              default: begin
                if (a == '0) begin
                  first_error = ST_DIVZERO;
                end else begin
                  mag_a = a[WORD_W-1] ? -a : a;
                  mag_b = b[WORD_W-1] ? -b : b;
                  quo = mag_b / mag_a;
                  r = (a[WORD_W-1] ^ b[WORD_W-1]) ? -quo : quo;
                end
              end
            endcase
            if (first_error == ST_OK) begin
              depth--;
              stack_mem[depth-1] = r;
            end
          end
        end else if (depth >= STACK_DEPTH_DEF) begin
          first_error = ST_OVERFLOW;
        end else begin
          stack_mem[depth] = WORD_W'(sym) - WORD_W'(SYM_ZERO);
          depth++;
        end
      end
      if (fin) begin
        res.value = '0;
        res.status = first_error;
        if (first_error == ST_OK) begin
          if (depth == 0) res.status = ST_EMPTY;
          else res.value = stack_mem[depth-1];
        end
        pending.push_back(res);
        depth = 0;
        first_error = ST_OK;
      end
    endfunction

    function void match_result(logic signed [WORD_W-1:0] v, logic [2:0] st);
      rpn_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result: value %0d status %0d", v, st);
        failures++;
        return;
      end
      exp_r = pending.pop_front();
      results_seen++;
      status_seen[exp_r.status]++;
      if (v !== exp_r.value) begin
        $error("value: expected %0d, got %0d", exp_r.value, v);
        failures++;
      end
      if (st !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, st);
        failures++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [7:0]               symbol;
  logic                     is_final;
  logic                     result_valid;
  logic signed [WORD_W-1:0] value;
  logic [2:0]               status;

  rpn_result_board sb;
  logic [7:0]      expr_q [$];
  int              idle_pct = 0;
  int              beats_sent = 0;
  int              cycle_count = 0;

  postfix_expression_evaluator u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .symbol       (symbol),
    .is_final     (is_final),
    .result_valid (result_valid),
    .value        (value),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("postfix_expression_evaluator verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid) sb.match_result(value, status);
  end

  function automatic logic [7:0] rand_operand();
    logic [7:0] v;
    if ($urandom_range(3) != 0) return SYM_ZERO + 8'($urandom_range(9));
    do v = 8'($urandom_range(255));
    while (v inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV});
    return v;
  endfunction

  function automatic logic [7:0] rand_operator();
    return OPERATORS[2'($urandom_range(3))];
  endfunction

  // Build a well-formed expression of n operands; pushes_first defers every operator.
  function automatic void build_expr(int n, bit pushes_first);
    int pushes, ops, level;
    expr_q.delete();
    pushes = n;
    ops = n - 1;
    level = 0;
    while (pushes + ops > 0) begin
      if (level >= 2 && ops > 0 && (pushes == 0 || (!pushes_first && $urandom_range(1)))) begin
        expr_q.push_back(rand_operator());
        ops--;
        level--;
      end else begin
        expr_q.push_back(rand_operand());
        pushes--;
        level++;
      end
    end
  endfunction

  task automatic send_beat(logic [7:0] sym, logic fin);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    symbol <= sym;
    is_final <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.take_symbol(sym, fin);
    beats_sent++;
  endtask

  task automatic send_expression();
    foreach (expr_q[i]) send_beat(expr_q[i], i == expr_q.size() - 1);
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int phase_pcts [4] = '{0, 72, 0, 21};
    int phase_end, k, idx;
    sb = new();
    rst <= 1'b1;
    start <= 1'b0;
    symbol <= '0;
    is_final <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    expr_q = '{SYM_ADD};
    send_expression();
    expr_q = '{SYM_ZERO + 8'd5, SYM_ZERO, SYM_DIV};
    send_expression();
    // most negative over minus one
    expr_q = '{8'hB0, 8'hB0, SYM_MUL, 8'hB0, SYM_MUL, 8'hB0, SYM_MUL, SYM_ZERO + 8'd8,
               SYM_MUL, SYM_ZERO, SYM_ZERO + 8'd1, SYM_SUB, SYM_DIV};
    send_expression();
    expr_q = '{8'h00, 8'hFF, SYM_SUB};
    send_expression();
    expr_q = '{SYM_ZERO + 8'd9, SYM_ZERO + 8'd4, SYM_ADD, SYM_ZERO + 8'd3, SYM_SUB};
    send_expression();
    drain_results();

    foreach (phase_pcts[p]) begin
      idle_pct = phase_pcts[p];
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) begin
        k = $urandom_range(99);
        if (k < 60) begin
          build_expr($urandom_range(1, 8), 1'b0);
        end else if (k < 72) begin
          build_expr($urandom_range(12, 18), 1'b1);
        end else if (k < 86) begin
          build_expr($urandom_range(2, 8), 1'b0);
          if ($urandom_range(1)) begin
            idx = $urandom_range(expr_q.size() - 1);
            expr_q.delete(idx);
          end else begin
            idx = $urandom_range(expr_q.size());
            expr_q.insert(idx, rand_operator());
          end
        end else begin
          expr_q.delete();
          repeat ($urandom_range(1, 6)) begin
            expr_q.push_back($urandom_range(1) ? rand_operator() : 8'($urandom_range(255)));
          end
        end
        send_expression();
        if ($urandom_range(39) == 0) drain_results();
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d symbol beats, checked %0d results over four pacing phases.",
             beats_sent, sb.results_seen);
    $display("Status mix: ok %0d, underflow %0d, overflow %0d, div-by-zero %0d, empty %0d.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4]);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("postfix_expression_evaluator verification clean");
    end else begin
      $display("postfix_expression_evaluator verification failed");
    end
    $finish;
  end

endmodule
